@@ rtl/core/tdee_pkg.sv @@
// ----------------------------------------------------------------------------
// tdee_pkg
// Shared types and constants for the two-voice duration event encoder.
// ----------------------------------------------------------------------------
package tdee_pkg;

    localparam int unsigned PITCH_W = 8;
    localparam int unsigned LEN_W   = 10;
    localparam int unsigned RUN_W   = 8;

    localparam logic [7:0] BASE_LENGTH_RST = 8'd120;
    localparam logic [RUN_W-1:0] RUN_LIMIT = 8'd250;
    localparam logic [RUN_W-1:0] RUN_MIN   = 8'd2;

    localparam logic OP_LINE  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // length codes, named by their fraction of the whole note
    localparam logic [3:0] LC_5_2  = 4'd0;
    localparam logic [3:0] LC_1    = 4'd1;
    localparam logic [3:0] LC_1_2  = 4'd2;
    localparam logic [3:0] LC_3_8  = 4'd3;
    localparam logic [3:0] LC_1_4  = 4'd4;
    localparam logic [3:0] LC_5_8  = 4'd5;
    localparam logic [3:0] LC_1_16 = 4'd6;
    localparam logic [3:0] LC_1_8  = 4'd8;
    localparam logic [3:0] LC_3_16 = 4'd9;
    localparam logic [3:0] LC_3_4  = 4'd10;
    localparam logic [3:0] LC_9_8  = 4'd11;
    localparam logic [3:0] LC_3_2  = 4'd12;
    localparam logic [3:0] LC_2    = 4'd13;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_A,
        ST_LOAD_B,
        ST_FRAME,
        ST_END,
        ST_FLUSH_REC,
        ST_FLUSH_TERM
    } state_t;

    typedef struct packed {
        logic [RUN_W-1:0]   duration;
        logic [PITCH_W-1:0] voice_a_pitch;
        logic [PITCH_W-1:0] voice_b_pitch;
        logic               last;
    } rec_t;

endpackage

@@ rtl/core/two_voice_duration_event_encoder_core.sv @@
// ----------------------------------------------------------------------------
// two_voice_duration_event_encoder_core
// Two-voice note lines in, run-length (duration, pitch A, pitch B) records out.
// ----------------------------------------------------------------------------
// After a note line is accepted, in_ready stays low while the core loads
// voice A, loads voice B, steps through base_length/16 frames and runs one
// closing step; the per-frame compare/decrement step is the unit that paces a
// line, and a full output register adds stalls. An end-of-song word emits
// the last run and a zero terminator. One record is held back inside so
// that the final record of each word carries last.
// ----------------------------------------------------------------------------
module two_voice_duration_event_encoder_core
    import tdee_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                opcode,
    input  logic                a_present,
    input  logic [PITCH_W-1:0]  a_pitch,
    input  logic [3:0]          a_length_code,
    input  logic                b_present,
    input  logic [PITCH_W-1:0]  b_pitch,
    input  logic [3:0]          b_length_code,
    input  logic                lyric_flag,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [RUN_W-1:0]    duration,
    output logic [PITCH_W-1:0]  voice_a_pitch,
    output logic [PITCH_W-1:0]  voice_b_pitch,
    output logic                last
);

    state_t state_reg, state_next;

    logic [7:0]         base_length_reg;
    logic [LEN_W-1:0]   a_rem_reg, a_rem_next, b_rem_reg, b_rem_next;
    logic [PITCH_W-1:0] a_cur_reg, a_cur_next, b_cur_reg, b_cur_next;
    logic [PITCH_W-1:0] a_prev_reg, a_prev_next, b_prev_reg, b_prev_next;
    logic [RUN_W-1:0]   run_reg, run_next;
    logic               first_reg, first_next;
    logic               lyric_reg, lyric_next;
    logic [3:0]         frames_reg, frames_next;

    // latched line word
    logic               a_pres_q, b_pres_q, lyric_q;
    logic [PITCH_W-1:0] a_pitch_q, b_pitch_q;
    logic [3:0]         a_code_q, b_code_q;

    // held record, waiting to learn whether it is the last one
    logic               hold_valid_reg, hold_valid_next;
    rec_t               hold_reg, hold_next;

    logic [3:0]         len_code;
    logic [LEN_W-1:0]   len;
    logic               push_valid, push_ready;
    rec_t               push_data;

    logic [PITCH_W-1:0] a_sil, b_sil;
    logic               emit;
    logic [RUN_W-1:0]   rec_dur;
    logic               frame_stall;
    logic               in_acc;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;

    assign len_code = (state_reg == ST_LOAD_A) ? a_code_q : b_code_q;

    tdee_len_unit u_len (
        .base_length (base_length_reg),
        .code        (len_code),
        .length      (len)
    );

    tdee_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .push_valid    (push_valid),
        .push_data     (push_data),
        .push_ready    (push_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .duration      (duration),
        .voice_a_pitch (voice_a_pitch),
        .voice_b_pitch (voice_b_pitch),
        .last          (last)
    );

    // frame step
    assign a_sil   = (a_rem_reg == '0) ? '0 : a_cur_reg;
    assign b_sil   = (b_rem_reg == '0) ? '0 : b_cur_reg;
    assign emit    = (a_sil != a_prev_reg) || (b_sil != b_prev_reg) || lyric_reg
                     || (run_reg > RUN_LIMIT);
    assign rec_dur = (run_reg < RUN_MIN) ? RUN_MIN : run_reg;
    assign frame_stall = emit && hold_valid_reg && !push_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (opcode == OP_FLUSH) ? ST_FLUSH_REC : ST_LOAD_A;
                end
            end
            ST_LOAD_A:
            begin
                state_next = ST_LOAD_B;
            end
            ST_LOAD_B:
            begin
                state_next = (base_length_reg[7:4] == 4'd0) ? ST_END : ST_FRAME;
            end
            ST_FRAME:
            begin
                if (!frame_stall && frames_reg == 4'd1)
                begin
                    state_next = ST_END;
                end
            end
            ST_END:
            begin
                if (!hold_valid_reg || push_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH_REC:
            begin
                if (push_ready)
                begin
                    state_next = ST_FLUSH_TERM;
                end
            end
            ST_FLUSH_TERM:
            begin
                if (push_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // record words toward the output register
    always_comb
    begin
        push_valid = 1'b0;
        push_data  = hold_reg;
        case (state_reg)
            ST_FRAME:
            begin
                push_valid     = emit && hold_valid_reg;
                push_data.last = 1'b0;
            end
            ST_END:
            begin
                push_valid     = hold_valid_reg;
                push_data.last = 1'b1;
            end
            ST_FLUSH_REC:
            begin
                push_valid              = 1'b1;
                push_data.duration      = (run_reg == 8'd1) ? RUN_MIN : run_reg;
                push_data.voice_a_pitch = a_prev_reg;
                push_data.voice_b_pitch = b_prev_reg;
                push_data.last          = 1'b0;
            end
            ST_FLUSH_TERM:
            begin
                push_valid = 1'b1;
                push_data  = '{duration: '0, voice_a_pitch: '0,
                               voice_b_pitch: '0, last: 1'b1};
            end
            default:
            begin
                push_valid = 1'b0;
            end
        endcase
    end

    // voice state datapath
    always_comb
    begin
        a_rem_next      = a_rem_reg;
        b_rem_next      = b_rem_reg;
        a_cur_next      = a_cur_reg;
        b_cur_next      = b_cur_reg;
        a_prev_next     = a_prev_reg;
        b_prev_next     = b_prev_reg;
        run_next        = run_reg;
        first_next      = first_reg;
        lyric_next      = lyric_reg;
        frames_next     = frames_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        case (state_reg)
            ST_LOAD_A:
            begin
                if (a_pres_q)
                begin
                    if (len != '0)
                    begin
                        a_rem_next = len;
                    end
                    if (a_pitch_q != '0)
                    begin
                        a_cur_next = a_pitch_q;
                    end
                end
            end
            ST_LOAD_B:
            begin
                if (b_pres_q)
                begin
                    if (len != '0)
                    begin
                        b_rem_next = len;
                    end
                    if (b_pitch_q != '0)
                    begin
                        b_cur_next = b_pitch_q;
                    end
                end
                if (lyric_q)
                begin
                    lyric_next = 1'b1;
                end
                if (first_reg)
                begin
                    a_prev_next = a_cur_reg;
                    b_prev_next = b_cur_next;
                    first_next  = 1'b0;
                end
                frames_next = base_length_reg[7:4];
            end
            ST_FRAME:
            begin
                if (!frame_stall)
                begin
                    if (emit)
                    begin
                        hold_valid_next = 1'b1;
                        hold_next = '{duration: rec_dur, voice_a_pitch: a_prev_reg,
                                      voice_b_pitch: b_prev_reg, last: 1'b0};
                        run_next  = 8'd1;
                    end
                    else
                    begin
                        run_next = run_reg + 8'd1;
                    end
                    if (a_rem_reg != '0)
                    begin
                        a_rem_next = a_rem_reg - 10'd1;
                    end
                    if (b_rem_reg != '0)
                    begin
                        b_rem_next = b_rem_reg - 10'd1;
                    end
                    a_cur_next  = a_sil;
                    b_cur_next  = b_sil;
                    a_prev_next = a_sil;
                    b_prev_next = b_sil;
                    lyric_next  = 1'b0;
                    frames_next = frames_reg - 4'd1;
                end
            end
            ST_END:
            begin
                if (push_ready)
                begin
                    hold_valid_next = 1'b0;
                end
            end
            ST_FLUSH_TERM:
            begin
                if (push_ready)
                begin
                    a_rem_next  = '0;
                    b_rem_next  = '0;
                    a_cur_next  = '0;
                    b_cur_next  = '0;
                    a_prev_next = '0;
                    b_prev_next = '0;
                    run_next    = '0;
                    first_next  = 1'b1;
                    lyric_next  = 1'b0;
                end
            end
            default:
            begin
                frames_next = frames_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            base_length_reg <= BASE_LENGTH_RST;
            a_rem_reg       <= '0;
            b_rem_reg       <= '0;
            a_cur_reg       <= '0;
            b_cur_reg       <= '0;
            a_prev_reg      <= '0;
            b_prev_reg      <= '0;
            run_reg         <= '0;
            first_reg       <= 1'b1;
            lyric_reg       <= 1'b0;
            frames_reg      <= '0;
            hold_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            a_rem_reg      <= a_rem_next;
            b_rem_reg      <= b_rem_next;
            a_cur_reg      <= a_cur_next;
            b_cur_reg      <= b_cur_next;
            a_prev_reg     <= a_prev_next;
            b_prev_reg     <= b_prev_next;
            run_reg        <= run_next;
            first_reg      <= first_next;
            lyric_reg      <= lyric_next;
            frames_reg     <= frames_next;
            hold_valid_reg <= hold_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                base_length_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        if (in_acc)
        begin
            a_pres_q  <= a_present;
            a_pitch_q <= a_pitch;
            a_code_q  <= a_length_code;
            b_pres_q  <= b_present;
            b_pitch_q <= b_pitch;
            b_code_q  <= b_length_code;
            lyric_q   <= lyric_flag;
        end
    end

    // a held record never outlives its line word
    a_hold_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("held record left over at idle");

    // run never grows past the limit plus one
    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg <= (RUN_LIMIT + 8'd1))
        else $error("run count above limit");

    // a stalled frame changes no voice state
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FRAME && frame_stall) |=>
            ($stable(run_reg) && $stable(a_rem_reg) && $stable(b_rem_reg)
             && $stable(frames_reg)))
        else $error("frame state moved during stall");

    // the terminator always closes a flush
    a_flush_term: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH_TERM && push_ready) |=>
            (out_valid && last && duration == '0))
        else $error("flush terminator missing");

endmodule

@@ rtl/core/tdee_len_unit.sv @@
// ----------------------------------------------------------------------------
// tdee_len_unit
// Length code to frame count, scaled from the base length. Shared by both
// voices; the sequencer presents one code per cycle.
// ----------------------------------------------------------------------------
module tdee_len_unit
    import tdee_pkg::*;
(
    input  logic [7:0]       base_length,
    input  logic [3:0]       code,
    output logic [LEN_W-1:0] length
);

    logic [11:0] l1;
    logic [11:0] l3;
    logic [11:0] l5;
    logic [11:0] l9;
    logic [11:0] scaled;

    // 9*255 needs twelve bits before the shift
    assign l1 = {4'b0000, base_length};
    assign l3 = {3'b000, base_length, 1'b0} + l1;
    assign l5 = {2'b00, base_length, 2'b00} + l1;
    assign l9 = {1'b0, base_length, 3'b000} + l1;

    always_comb
    begin
        case (code)
            LC_5_2:  scaled = l5 >> 1;
            LC_1:    scaled = l1;
            LC_1_2:  scaled = l1 >> 1;
            LC_3_8:  scaled = l3 >> 3;
            LC_1_4:  scaled = l1 >> 2;
            LC_5_8:  scaled = l5 >> 3;
            LC_1_16: scaled = l1 >> 4;
            LC_1_8:  scaled = l1 >> 3;
            LC_3_16: scaled = l3 >> 4;
            LC_3_4:  scaled = l3 >> 2;
            LC_9_8:  scaled = l9 >> 3;
            LC_3_2:  scaled = l3 >> 1;
            LC_2:    scaled = l1 << 1;
            default: scaled = 12'd1;
        endcase
    end

    // largest value is 5*255/2 = 637, fits in ten bits
    assign length = scaled[LEN_W-1:0];

endmodule

@@ rtl/core/tdee_out_reg.sv @@
// ----------------------------------------------------------------------------
// tdee_out_reg
// Output register for record words. Takes a new word in the cycle the held
// word leaves.
// ----------------------------------------------------------------------------
module tdee_out_reg
    import tdee_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  rec_t                push_data,
    output logic                push_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [RUN_W-1:0]    duration,
    output logic [PITCH_W-1:0]  voice_a_pitch,
    output logic [PITCH_W-1:0]  voice_b_pitch,
    output logic                last
);

    logic valid_reg;
    rec_t data_reg;

    assign push_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push_ready)
        begin
            valid_reg <= push_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ready && push_valid)
        begin
            data_reg <= push_data;
        end
    end

    assign out_valid     = valid_reg;
    assign duration      = data_reg.duration;
    assign voice_a_pitch = data_reg.voice_a_pitch;
    assign voice_b_pitch = data_reg.voice_b_pitch;
    assign last          = data_reg.last;

endmodule

@@ tb/two_voice_duration_event_encoder_core_tb.sv @@
// ----------------------------------------------------------------------------
// two_voice_duration_event_encoder_core_tb
// Self-checking bench for the two-voice duration event encoder: note lines and
// end-of-song words go in, and a scoreboard tracks both voices frame by frame to
// predict each run-length record, including the last flag. Input and output
// channels idle and stall at random. The bench covers several base lengths:
// below one frame per line, the smallest and largest legal values, and the
// full 8-bit range.
// ----------------------------------------------------------------------------
module two_voice_duration_event_encoder_core_tb;
    import tdee_pkg::*;

    // a 15-frame line plus output stalls clears well inside the watchdog limit
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 32;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 50;

    typedef struct packed {
        logic               opcode;
        logic               a_present;
        logic [PITCH_W-1:0] a_pitch;
        logic [3:0]         a_length_code;
        logic               b_present;
        logic [PITCH_W-1:0] b_pitch;
        logic [3:0]         b_length_code;
        logic               lyric_flag;
    } note_word_t;

    class duration_record_scoreboard;
        logic [7:0]         base_length;
        logic [LEN_W-1:0]   a_left, b_left;
        logic [PITCH_W-1:0] a_now, b_now, a_run, b_run;
        logic [RUN_W-1:0]   run_len;
        bit                 first_line, lyric_waiting;
        rec_t               held;
        bit                 have_held;
        rec_t               expected_records[$];
        int unsigned        errors;

        function new();
            base_length = BASE_LENGTH_RST;
            errors      = 0;
            have_held   = 0;
            clear_voices();
        endfunction

        function void clear_voices();
            a_left        = '0;
            b_left        = '0;
            a_now         = '0;
            b_now         = '0;
            a_run         = '0;
            b_run         = '0;
            run_len       = '0;
            first_line    = 1;
            lyric_waiting = 0;
        endfunction

        function void set_base_length(logic [7:0] value);
            base_length = value;
        endfunction

        function logic [LEN_W-1:0] scaled_length(logic [3:0] code);
            logic [11:0] l;
            l = {4'd0, base_length};
            case (code)
                LC_5_2:  return LEN_W'((l * 12'd5) / 12'd2);
                LC_1:    return LEN_W'(l);
                LC_1_2:  return LEN_W'(l / 12'd2);
                LC_3_8:  return LEN_W'((l * 12'd3) / 12'd8);
                LC_1_4:  return LEN_W'(l / 12'd4);
                LC_5_8:  return LEN_W'((l * 12'd5) / 12'd8);
                LC_1_16: return LEN_W'(l / 12'd16);
                LC_1_8:  return LEN_W'(l / 12'd8);
                LC_3_16: return LEN_W'((l * 12'd3) / 12'd16);
                LC_3_4:  return LEN_W'((l * 12'd3) / 12'd4);
                LC_9_8:  return LEN_W'((l * 12'd9) / 12'd8);
                LC_3_2:  return LEN_W'((l * 12'd3) / 12'd2);
                LC_2:    return LEN_W'(l * 12'd2);
                default: return LEN_W'(1);
            endcase
        endfunction

        // one record is held back so the final one of a word gets last
        function void emit_run(logic [RUN_W-1:0] dur, logic [PITCH_W-1:0] pa,
                               logic [PITCH_W-1:0] pb);
            if (have_held)
                expected_records.push_back(held);
            held.duration      = dur;
            held.voice_a_pitch = pa;
            held.voice_b_pitch = pb;
            held.last          = 1'b0;
            have_held          = 1;
        endfunction

        function void close_word();
            if (have_held) begin
                held.last = 1'b1;
                expected_records.push_back(held);
                have_held = 0;
            end
        endfunction

        function void note_word(note_word_t w);
            logic [LEN_W-1:0] len;
            int               frames;
            int               f;
            if (w.opcode == OP_FLUSH) begin
                emit_run((run_len == 8'd1) ? RUN_MIN : run_len, a_run, b_run);
                emit_run(8'd0, 8'd0, 8'd0);
                close_word();
                clear_voices();
                return;
            end
            if (w.a_present) begin
                len = scaled_length(w.a_length_code);
                if (len != '0)
                    a_left = len;
                if (w.a_pitch != '0)
                    a_now = w.a_pitch;
            end
            if (w.b_present) begin
                len = scaled_length(w.b_length_code);
                if (len != '0)
                    b_left = len;
                if (w.b_pitch != '0)
                    b_now = w.b_pitch;
            end
            if (w.lyric_flag)
                lyric_waiting = 1;
            if (first_line) begin
                a_run      = a_now;
                b_run      = b_now;
                first_line = 0;
            end
            frames = int'(base_length >> 4);
            for (f = 0; f < frames; f++) begin
                if (a_left == '0)
                    a_now = '0;
                if (b_left == '0)
                    b_now = '0;
                if (a_now != a_run || b_now != b_run || lyric_waiting || run_len > RUN_LIMIT) begin
                    emit_run((run_len < RUN_MIN) ? RUN_MIN : run_len, a_run, b_run);
                    run_len = '0;
                end
                run_len = run_len + 1'b1;
                if (a_left != '0)
                    a_left = a_left - 1'b1;
                if (b_left != '0)
                    b_left = b_left - 1'b1;
                a_run         = a_now;
                b_run         = b_now;
                lyric_waiting = 0;
            end
            close_word();
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_record(rec_t got);
            rec_t want;
            if (expected_records.size() == 0) begin
                $display("%0t: unexpected record, expected none, got dur %0d a %0d b %0d last %0b",
                         $time, got.duration, got.voice_a_pitch, got.voice_b_pitch, got.last);
                errors++;
                return;
            end
            want = expected_records.pop_front();
            compare_field("duration", int'(want.duration), int'(got.duration));
            compare_field("voice_a_pitch", int'(want.voice_a_pitch), int'(got.voice_a_pitch));
            compare_field("voice_b_pitch", int'(want.voice_b_pitch), int'(got.voice_b_pitch));
            compare_field("last", int'(want.last), int'(got.last));
        endfunction

        function int pending();
            return expected_records.size();
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_data  = 8'd0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    note_word_t         in_word   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [RUN_W-1:0]   duration;
    logic [PITCH_W-1:0] voice_a_pitch;
    logic [PITCH_W-1:0] voice_b_pitch;
    logic               last;

    bit                 steady = 0;
    int                 stall_cycles = 0;
    duration_record_scoreboard sb;

    two_voice_duration_event_encoder_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (in_word.opcode),
        .a_present     (in_word.a_present),
        .a_pitch       (in_word.a_pitch),
        .a_length_code (in_word.a_length_code),
        .b_present     (in_word.b_present),
        .b_pitch       (in_word.b_pitch),
        .b_length_code (in_word.b_length_code),
        .lyric_flag    (in_word.lyric_flag),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .duration      (duration),
        .voice_a_pitch (voice_a_pitch),
        .voice_b_pitch (voice_b_pitch),
        .last          (last)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
        out_ready <= steady || ($urandom_range(99) >= 15);

    always @(posedge clk)
    begin : monitor
        rec_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_base_length(cfg_data);
            if (in_valid && in_ready)
                sb.note_word(in_word);
            if (out_valid && out_ready)
            begin
                got.duration      = duration;
                got.voice_a_pitch = voice_a_pitch;
                got.voice_b_pitch = voice_b_pitch;
                got.last          = last;
                sb.check_record(got);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [PITCH_W-1:0] random_pitch();
        case ($urandom_range(2))
            0:       return 8'd0;
            1:       return 8'($urandom_range(4, 1) * 60);  // small set, so pitches repeat
            default: return 8'($urandom_range(255, 1));
        endcase
    endfunction

    function automatic note_word_t random_line(int density);
        note_word_t w;
        w.opcode        = OP_LINE;
        w.a_present     = ($urandom_range(99) < density);
        w.a_pitch       = random_pitch();
        w.a_length_code = 4'($urandom_range(15));
        w.b_present     = ($urandom_range(99) < density);
        w.b_pitch       = random_pitch();
        w.b_length_code = 4'($urandom_range(15));
        w.lyric_flag    = ($urandom_range(99) < 8);
        return w;
    endfunction

    function automatic note_word_t flush_word();
        note_word_t w;
        w        = random_line(50);  // other fields are don't-care on a flush
        w.opcode = OP_FLUSH;
        return w;
    endfunction

    function automatic note_word_t make_line(logic ap, logic [7:0] apitch, logic [3:0] acode,
                                             logic bp, logic [7:0] bpitch, logic [3:0] bcode,
                                             logic lyric);
        note_word_t w;
        w.opcode        = OP_LINE;
        w.a_present     = ap;
        w.a_pitch       = apitch;
        w.a_length_code = acode;
        w.b_present     = bp;
        w.b_pitch       = bpitch;
        w.b_length_code = bcode;
        w.lyric_flag    = lyric;
        return w;
    endfunction

    function automatic int pick_density();
        case ($urandom_range(2))
            0:       return 5;   // long silences, runs hit the limit
            1:       return 40;
            default: return 80;
        endcase
    endfunction

    task automatic send_word(input note_word_t w);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_base_length(input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drain all records, then give a word that emits nothing time to finish
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] bases [NUM_PHASES];
        int         phase, k, c, song_left, density;

        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed lines at the reset base length
        send_word(flush_word());  // flush with no line: zero run then terminator
        send_word(make_line(1'b1, 8'd255, LC_5_2, 1'b1, 8'd1, LC_2, 1'b1));
        send_word(make_line(1'b1, 8'd0, LC_1, 1'b0, 8'd0, LC_1, 1'b0));
        for (c = 0; c < 16; c++)
            send_word(make_line(1'b1, 8'(c * 16 + 3), 4'(c), 1'b1, 8'(200 - c), 4'(15 - c),
                                (c % 5) == 0));
        send_word(make_line(1'b0, 8'd0, LC_1, 1'b0, 8'd0, LC_1, 1'b1));
        send_word(make_line(1'b0, 8'd0, LC_1, 1'b0, 8'd0, LC_1, 1'b0));
        send_word(make_line(1'b0, 8'd0, LC_1, 1'b0, 8'd0, LC_1, 1'b0));
        send_word(flush_word());

        // below 16 no frames run; 0 and 9 also make short codes scale to zero
        bases = '{8'd16, 8'd240, 8'd255, 8'd0, 8'd9, 8'($urandom_range(240, 16)),
                  8'($urandom_range(255)), BASE_LENGTH_RST};
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle();
            write_base_length(bases[phase]);
            steady    = (phase == 3);
            song_left = $urandom_range(30, 4);
            density   = pick_density();
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (song_left == 0)
                begin
                    send_word(flush_word());
                    song_left = $urandom_range(30, 4);
                    density   = pick_density();
                end
                else
                begin
                    if ($urandom_range(9) == 0)
                        send_word(random_line(50));
                    else
                        send_word(random_line(density));
                    song_left--;
                end
            end
        end
        steady = 0;

        settle();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
